// ===== src/caladd_pkg.sv =====
// shared types, constants and calendar helpers for the date and time adder
`default_nettype none

package caladd_pkg;

  localparam int unsigned SECS_PER_MIN  = 60;
  localparam int unsigned MINS_PER_HOUR = 60;
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MONTH_WRAP    = 13;
  localparam int unsigned LEAP_PERIOD   = 4;

  // reciprocal constants: q = (x * RECIP) >> SHIFT is exact or one low for x < 2**32
  localparam logic [31:0] RECIP_60 = 32'd2290649224;
  localparam int unsigned SHIFT_60 = 37;
  localparam logic [31:0] RECIP_24 = 32'd2863311530;
  localparam int unsigned SHIFT_24 = 36;

  // request word
  typedef struct packed {
    logic [5:0]  start_second;
    logic [5:0]  start_minute;
    logic [4:0]  start_hour;
    logic [4:0]  start_day;
    logic [3:0]  start_month;
    logic [15:0] start_year;
    logic [30:0] add_seconds;
  } req_t;

  // response word
  typedef struct packed {
    logic [5:0]  new_second;
    logic [5:0]  new_minute;
    logic [4:0]  new_hour;
    logic [4:0]  new_day;
    logic [3:0]  new_month;
    logic [15:0] new_year;
  } rsp_t;

  // length of a month, february long in every year divisible by four
  function automatic logic [4:0] days_in(input logic [3:0] month, input logic [15:0] year);
    logic [4:0] len;
    case (month) inside
      4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
      4'd2:    len = (year % LEAP_PERIOD == 0) ? 5'd29 : 5'd28;
      default: len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

`default_nettype wire

// ===== src/calendar_add_seconds.sv =====
// calendar date and time plus a count of seconds, microcoded sequencer
//
// Usage: a request word (start date, start time, seconds to add) enters on
// the req channel when req_valid is high and req_stall is low; the result
// word leaves on the rsp channel when rsp_valid is high and rsp_stall is low.
// The block works on one word at a time. A small program steps a shared
// datapath: three reciprocal divisions (by 60, 60 and 24), each taking a
// multiply, a remainder and a correction step, then a month step repeated
// while the day count exceeds the current month's length. A new word is taken
// only once the previous result has gone into the output register. The month
// step covers no months for short additions, up to about 820 for the largest.
// The result sits in an output register: while the receiver stalls, the
// block finishes its current word and waits in its output step; the word
// already in the output register holds until taken. Reset (rst, synchronous)
// returns the step counter to the wait step and empties the output register.
`default_nettype none

module calendar_add_seconds (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 req_valid,
  output logic                req_stall,
  input  caladd_pkg::req_t    req,
  output logic                rsp_valid,
  input  wire                 rsp_stall,
  output caladd_pkg::rsp_t    rsp
);

  import caladd_pkg::*;

  // microcode word
  typedef enum logic [2:0] {OP_WAIT, OP_MUL, OP_REM, OP_FIX, OP_MONTH, OP_EMIT} op_t;
  typedef enum logic [1:0] {COND_NONE, COND_NO_INPUT, COND_LONG_MONTH, COND_OUT_BUSY} cond_t;
  typedef enum logic [0:0] {DIV_60, DIV_24} div_t;
  typedef enum logic [1:0] {DST_SEC, DST_MIN, DST_HOUR} dst_t;

  localparam int unsigned PROG_LEN = 12;
  localparam int unsigned PC_W     = $clog2(PROG_LEN);
  localparam logic [PC_W-1:0] PROG_LAST = PC_W'(PROG_LEN - 1);

  typedef struct packed {
    op_t             op;
    cond_t           cond;
    div_t            div;
    dst_t            dst;
    logic [PC_W-1:0] target;
  } cw_t;

  // control store: jump to target when the condition holds, else fall through
  function automatic cw_t program_step(input logic [PC_W-1:0] addr);
    cw_t w;
    w = '{op: OP_WAIT, cond: COND_NONE, div: DIV_60, dst: DST_SEC, target: '0};
    case (addr)
      PC_W'(0):  w = '{OP_WAIT,  COND_NO_INPUT,   DIV_60, DST_SEC,  PC_W'(0)};
      PC_W'(1):  w = '{OP_MUL,   COND_NONE,       DIV_60, DST_SEC,  PC_W'(0)};
      PC_W'(2):  w = '{OP_REM,   COND_NONE,       DIV_60, DST_SEC,  PC_W'(0)};
      PC_W'(3):  w = '{OP_FIX,   COND_NONE,       DIV_60, DST_SEC,  PC_W'(0)};
      PC_W'(4):  w = '{OP_MUL,   COND_NONE,       DIV_60, DST_MIN,  PC_W'(0)};
      PC_W'(5):  w = '{OP_REM,   COND_NONE,       DIV_60, DST_MIN,  PC_W'(0)};
      PC_W'(6):  w = '{OP_FIX,   COND_NONE,       DIV_60, DST_MIN,  PC_W'(0)};
      PC_W'(7):  w = '{OP_MUL,   COND_NONE,       DIV_24, DST_HOUR, PC_W'(0)};
      PC_W'(8):  w = '{OP_REM,   COND_NONE,       DIV_24, DST_HOUR, PC_W'(0)};
      PC_W'(9):  w = '{OP_FIX,   COND_NONE,       DIV_24, DST_HOUR, PC_W'(0)};
      PC_W'(10): w = '{OP_MONTH, COND_LONG_MONTH, DIV_24, DST_HOUR, PC_W'(10)};
      PC_W'(11): w = '{OP_EMIT,  COND_OUT_BUSY,   DIV_24, DST_HOUR, PC_W'(11)};
      default:   w = '{OP_WAIT,  COND_NONE,       DIV_60, DST_SEC,  PC_W'(0)};
    endcase
    return w;
  endfunction

  logic [PC_W-1:0] pc;
  logic [PC_W-1:0] pc_next;
  cw_t             cw;

  // datapath registers
  logic [31:0] acc;
  logic [27:0] quo;
  logic [6:0]  rem;
  logic [5:0]  sec;
  logic [5:0]  min;
  logic [4:0]  hour;
  logic [14:0] day;
  logic [3:0]  month;
  logic [15:0] year;

  logic [5:0]  divisor;
  logic [31:0] recip;
  logic [63:0] prod;
  logic [27:0] quo_est;
  logic [33:0] quo_times_div;
  logic [31:0] rem_wide;
  logic        rem_high;
  logic [6:0]  rem_fix;
  logic [27:0] quo_fix;
  logic [4:0]  dim;
  logic        long_month;
  logic        req_fire;
  logic        out_busy;
  logic        cond_true;
  logic [3:0]  start_month_norm;
  logic [15:0] start_year_norm;

  assign cw = program_step(pc);

  // divisor and reciprocal selection
  assign divisor = (cw.div == DIV_60) ? 6'(SECS_PER_MIN) : 6'(HOURS_PER_DAY);
  assign recip   = (cw.div == DIV_60) ? RECIP_60 : RECIP_24;

  // quotient estimate, then remainder, then one correction
  assign prod          = 64'(acc) * 64'(recip);
  assign quo_est       = (cw.div == DIV_60) ? {1'b0, prod[63:SHIFT_60]} : prod[63:SHIFT_24];
  assign quo_times_div = 34'(quo) * 34'(divisor);
  assign rem_wide      = acc - quo_times_div[31:0];
  assign rem_high      = (rem >= {1'b0, divisor});
  assign rem_fix       = rem_high ? (rem - {1'b0, divisor}) : rem;
  assign quo_fix       = rem_high ? (quo + 28'd1) : quo;

  // month stepping test
  assign dim        = days_in(month, year);
  assign long_month = (day > {10'd0, dim});

  // start month normalization
  always_comb begin
    start_month_norm = req.start_month;
    start_year_norm  = req.start_year;
    if (req.start_month == 4'd0) begin
      start_month_norm = 4'd1;
    end else if (req.start_month >= 4'(MONTH_WRAP)) begin
      start_month_norm = 4'd1;
      start_year_norm  = req.start_year + 16'd1;
    end
  end

  // handshakes
  assign req_stall = (cw.op != OP_WAIT);
  assign req_fire  = req_valid && !req_stall;
  assign out_busy  = rsp_valid && rsp_stall;

  // sequencer branch
  always_comb begin
    case (cw.cond)
      COND_NONE:       cond_true = 1'b0;
      COND_NO_INPUT:   cond_true = !req_valid;
      COND_LONG_MONTH: cond_true = long_month;
      COND_OUT_BUSY:   cond_true = out_busy;
      default:         cond_true = 1'b0;
    endcase
    if (cond_true) begin
      pc_next = cw.target;
    end else if (pc == PROG_LAST) begin
      pc_next = '0;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  // step counter, datapath and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cw.op == OP_EMIT && !out_busy) begin
        rsp_valid <= 1'b1;
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end

    case (cw.op)
      OP_WAIT: begin
        if (req_fire) begin
          acc   <= 32'(req.start_second) + 32'(req.add_seconds);
          min   <= req.start_minute;
          hour  <= req.start_hour;
          day   <= 15'(req.start_day);
          month <= start_month_norm;
          year  <= start_year_norm;
        end
      end
      OP_MUL: begin
        quo <= quo_est;
      end
      OP_REM: begin
        rem <= rem_wide[6:0];
      end
      OP_FIX: begin
        case (cw.dst)
          DST_SEC: begin
            sec <= rem_fix[5:0];
            acc <= 32'(min) + 32'(quo_fix);
          end
          DST_MIN: begin
            min <= rem_fix[5:0];
            acc <= 32'(hour) + 32'(quo_fix);
          end
          DST_HOUR: begin
            hour <= rem_fix[4:0];
            day  <= day + quo_fix[14:0];
          end
          default: begin
            sec <= rem_fix[5:0];
          end
        endcase
      end
      OP_MONTH: begin
        if (long_month) begin
          day <= day - {10'd0, dim};
          if (month == 4'(MONTH_WRAP - 1)) begin
            month <= 4'd1;
            year  <= year + 16'd1;
          end else begin
            month <= month + 4'd1;
          end
        end
      end
      OP_EMIT: begin
        if (!out_busy) begin
          rsp.new_second <= sec;
          rsp.new_minute <= min;
          rsp.new_hour   <= hour;
          rsp.new_day    <= day[4:0];
          rsp.new_month  <= month;
          rsp.new_year   <= year;
        end
      end
      default: begin
        quo <= quo;
      end
    endcase
  end

  // checks
  a_rem_bound: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_FIX) |-> (rem < {divisor, 1'b0}))
    else $error("remainder estimate off by more than one divisor");

  a_month_range: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_MONTH) |-> (month >= 4'd1 && month <= 4'(MONTH_WRAP - 1)))
    else $error("month out of range while stepping");

  a_day_fits: assert property (@(posedge clk) disable iff (rst)
    (cw.op == OP_EMIT) |-> (day <= {10'd0, dim}))
    else $error("day exceeds month length at output");

  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && !rsp_stall && cw.op != OP_EMIT) |=> !rsp_valid)
    else $error("output word not released after it was taken");

  a_pc_range: assert property (@(posedge clk) disable iff (rst)
    pc <= PROG_LAST)
    else $error("step counter outside program");

endmodule

`default_nettype wire
